>>> src/kqr_pkg.sv
// ----------------------------------------------------------------------------
// kqr_pkg
// Shared widths, character constants and the elaboration-time builder of the
// log-domain term table used by the k-mer quality re-encoder.
// ----------------------------------------------------------------------------
package kqr_pkg;

  localparam int QUAL_W     = 7;
  localparam int K_CFG_W    = 7;
  localparam int K_RESET    = 2;
  localparam int TERM_COUNT = 187;
  localparam int TOP_SCORE  = 93;
  localparam int SCORE_W    = 7;

  localparam logic [QUAL_W-1:0] CHAR_BIAS = 7'd33;

  localparam logic [63:0] Q62_ONE   = 64'h4000_0000_0000_0000;
  localparam logic [63:0] Q62_TWO   = 64'h8000_0000_0000_0000;
  localparam logic [63:0] Q62_TENTH = Q62_ONE / 10;

  typedef logic [TERM_COUNT-1:0][63:0] term_tab_t;

  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  function automatic logic [63:0] log2_frac(input logic [63:0] z_in);
    logic [63:0] z;
    logic [63:0] f;
    z = z_in;
    f = '0;
    for (int i = 1; i <= 60; i++) begin
      z = mul_q62(z, z);
      if (z >= Q62_TWO) begin
        z = z >> 1;
        f[60-i] = 1'b1;
      end
    end
    return f;
  endfunction

  function automatic logic [63:0] neg_log2(input logic [63:0] z_in);
    logic [63:0] z;
    logic [63:0] n;
    z = z_in;
    n = '0;
    if (z == '0) begin
      return 64'd7 << 60;
    end
    for (int i = 0; i < 7; i++) begin
      if (z < Q62_ONE) begin
        z = z << 1;
        n = n + 64'd1;
      end
    end
    return (n << 60) - log2_frac(z);
  endfunction

  // term(h) = -log10(1 - 10^(-h/20)), rounded to frac_bits fraction bits
  function automatic term_tab_t build_terms(input int frac_bits);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] p;
    logic [63:0] x;
    logic [63:0] l10;
    logic [63:0] num;
    logic [63:0] q;
    logic [63:0] rem;
    term_tab_t   tab;
    lo  = '0;
    hi  = Q62_ONE;
    tab = '0;
    for (int i = 0; i < 64; i++) begin
      mid = lo + ((hi - lo) >> 1);
      p   = Q62_ONE;
      for (int j = 0; j < 20; j++) begin
        p = mul_q62(p, mid);
      end
      if (p <= Q62_TENTH) begin
        lo = mid;
      end else begin
        hi = mid;
      end
    end
    l10 = (64'd3 << 60) + log2_frac(Q62_ONE + (Q62_ONE >> 2));
    x   = Q62_ONE;
    for (int h = 1; h < TERM_COUNT; h++) begin
      x   = mul_q62(x, lo);
      num = neg_log2(Q62_ONE - x);
      q   = '0;
      rem = num;
      for (int j = 0; j < 4; j++) begin
        if (rem >= l10) begin
          rem = rem - l10;
          q   = q + 64'd1;
        end
      end
      for (int i = 0; i <= frac_bits; i++) begin
        rem = rem << 1;
        q   = q << 1;
        if (rem >= l10) begin
          rem  = rem - l10;
          q[0] = 1'b1;
        end
      end
      tab[h] = (q + 64'd1) >> 1;
    end
    return tab;
  endfunction

endpackage

>>> src/kqr_if.sv
// ----------------------------------------------------------------------------
// kqr_if
// Valid/ready stream interfaces for quality words in and re-encoded words out.
// ----------------------------------------------------------------------------
interface kqr_in_if;
  logic                        valid;
  logic                        ready;
  logic [kqr_pkg::QUAL_W-1:0]  qual_char;
  logic                        first_of_read;

  modport source (output valid, output qual_char, output first_of_read, input ready);
  modport sink   (input valid, input qual_char, input first_of_read, output ready);
endinterface

interface kqr_out_if;
  logic                        valid;
  logic                        ready;
  logic [kqr_pkg::QUAL_W-1:0]  score_char;

  modport source (output valid, output score_char, input ready);
  modport sink   (input valid, input score_char, output ready);
endinterface

>>> src/kqr_ram.sv
// ----------------------------------------------------------------------------
// kqr_ram
// Generic simple dual-port RAM, one write and one registered read port,
// read-first when both ports hit the same entry.
// ----------------------------------------------------------------------------
module kqr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> src/kmer_quality_reencoder_unit.sv
// ----------------------------------------------------------------------------
// kmer_quality_reencoder_unit
// Re-encodes Sanger quality words into k-mer quality words in the log domain.
// ----------------------------------------------------------------------------
// The unit takes one quality word per cycle unless a full pipeline is held by
// the output side, and returns one word per input word, in order, through the registered stages b, c, d and o.
// The first word of a read passes through unchanged, clears the window and
// latches window_k (clamped to 1..MAX_WINDOW); later words give the rounded
// phred score of the window of the last k positions, or '!' when the window
// holds a zero-quality base. Terms sit in a ring RAM of MAX_WINDOW entries,
// written and read once per later word; the window sum register is updated
// by one add and subtract per word, so the sustained rate is one word per
// cycle unless the output stalls. The ring needs no clearing pass after reset.
module kmer_quality_reencoder_unit #(
  parameter int MAX_WINDOW = 64,
  parameter int FRAC_BITS  = 40
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [kqr_pkg::K_CFG_W-1:0]  cfg_wdata,
  kqr_in_if.sink                       in_chan,
  kqr_out_if.source                    out_chan
);

  import kqr_pkg::*;

  localparam int TERM_W = FRAC_BITS + 1;
  localparam int AW     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int AX     = AW + 2;
  localparam int KW     = $clog2(MAX_WINDOW + 2);
  localparam int SUM_W  = FRAC_BITS + KW + 1;

  localparam term_tab_t TERM_TAB = build_terms(FRAC_BITS);
  localparam logic [TERM_W-1:0] ZERO_MARK = {1'b1, {FRAC_BITS{1'b0}}};

  logic [K_CFG_W-1:0] cfg_k_r;
  logic [KW-1:0]      k_lat_r, k_lat_nxt;
  logic [KW-1:0]      fill_r, fill_nxt;
  logic [AW-1:0]      ptr_r, ptr_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [KW-1:0]      zc_r, zc_nxt;

  logic b_en, c_en, d_en, o_en;
  logic in_acc;
  logic b_v_r, c_v_r, d_v_r, o_v_r;

  logic [QUAL_W-1:0] b_qc_r, c_qc_r, d_qc_r, o_char_r;
  logic              b_first_r, c_first_r, d_first_r;
  logic              b_evict_r;
  logic [TERM_W-1:0] b_entry_r;
  logic [SUM_W-1:0]  c_sum_r;
  logic              c_zero_r, d_zero_r;
  logic [TOP_SCORE-1:0] ge_c, d_ge_r;

  logic [6:0]        qscore;
  logic [7:0]        term_idx;
  logic [TERM_W-1:0] entry;
  logic              evict;
  logic [KW-1:0]     k_addr;
  logic [AX-1:0]     old_sum;
  logic [AW-1:0]     old_addr;
  logic              ring_wr;
  logic [TERM_W-1:0] ring_rd;

  logic [SUM_W-1:0]  sub_val, add_val;
  logic              zc_dec, zc_inc;
  logic [SCORE_W-1:0] score;
  logic [QUAL_W-1:0] o_char_nxt;

  // stall chain
  assign o_en   = !o_v_r || out_chan.ready;
  assign d_en   = !d_v_r || o_en;
  assign c_en   = !c_v_r || d_en;
  assign b_en   = !b_v_r || c_en;
  assign in_chan.ready = b_en;
  assign in_acc = in_chan.valid && b_en;

  // word classification and ring addressing
  always_comb begin
    if (in_chan.qual_char < CHAR_BIAS) begin
      qscore = '0;
    end else if (in_chan.qual_char - CHAR_BIAS > 7'(TOP_SCORE)) begin
      qscore = 7'(TOP_SCORE);
    end else begin
      qscore = in_chan.qual_char - CHAR_BIAS;
    end
    term_idx = {qscore, 1'b0};
    entry    = (qscore == '0) ? ZERO_MARK : TERM_TAB[term_idx][TERM_W-1:0];
    evict    = fill_r >= k_lat_r;
    k_addr   = (int'(k_lat_r) > MAX_WINDOW) ? KW'(MAX_WINDOW) : k_lat_r;
    old_sum  = AX'(ptr_r) + AX'(MAX_WINDOW) - AX'(k_addr);
    if (int'(old_sum) >= MAX_WINDOW) begin
      old_addr = AW'(old_sum - AX'(MAX_WINDOW));
    end else begin
      old_addr = AW'(old_sum);
    end
    ring_wr = in_acc && !in_chan.first_of_read;
  end

  // ring pointer, fill and window length advance at acceptance
  always_comb begin
    k_lat_nxt = k_lat_r;
    fill_nxt  = fill_r;
    ptr_nxt   = ptr_r;
    if (in_acc) begin
      if (in_chan.first_of_read) begin
        fill_nxt = '0;
        ptr_nxt  = '0;
        if (cfg_k_r == '0) begin
          k_lat_nxt = KW'(1);
        end else if (int'(cfg_k_r) > MAX_WINDOW) begin
          k_lat_nxt = KW'(MAX_WINDOW);
        end else begin
          k_lat_nxt = KW'(cfg_k_r);
        end
      end else begin
        if (!evict) begin
          fill_nxt = fill_r + 1'b1;
        end
        ptr_nxt = (int'(ptr_r) == MAX_WINDOW - 1) ? '0 : ptr_r + 1'b1;
      end
    end
  end

  kqr_ram #(
    .WIDTH (TERM_W),
    .DEPTH (MAX_WINDOW),
    .AW    (AW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ring_wr),
    .wr_addr (ptr_r),
    .wr_data (entry),
    .rd_en   (ring_wr),
    .rd_addr (old_addr),
    .rd_data (ring_rd)
  );

  // window sum and zero count update with the evicted term
  always_comb begin
    sub_val = (b_evict_r && !ring_rd[FRAC_BITS]) ? SUM_W'(ring_rd) : '0;
    add_val = b_entry_r[FRAC_BITS] ? '0 : SUM_W'(b_entry_r);
    zc_dec  = b_evict_r && ring_rd[FRAC_BITS] && (zc_r != '0);
    zc_inc  = b_entry_r[FRAC_BITS];
    if (b_first_r) begin
      sum_nxt = '0;
      zc_nxt  = '0;
    end else begin
      sum_nxt = sum_r - sub_val + add_val;
      zc_nxt  = zc_r - KW'(zc_dec) + KW'(zc_inc);
    end
  end

  always_comb begin
    for (int m = 0; m < TOP_SCORE; m++) begin
      ge_c[m] = c_sum_r <= SUM_W'(TERM_TAB[2*m+1][TERM_W-1:0]);
    end
  end

  always_comb begin
    score = '0;
    for (int m = 0; m < TOP_SCORE; m++) begin
      score = score + SCORE_W'(d_ge_r[m]);
    end
    if (d_first_r) begin
      o_char_nxt = d_qc_r;
    end else if (d_zero_r) begin
      o_char_nxt = CHAR_BIAS;
    end else begin
      o_char_nxt = CHAR_BIAS + QUAL_W'(score);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_k_r <= K_CFG_W'(K_RESET);
      k_lat_r <= KW'(K_RESET);
      fill_r  <= '0;
      ptr_r   <= '0;
      sum_r   <= '0;
      zc_r    <= '0;
      b_v_r   <= 1'b0;
      c_v_r   <= 1'b0;
      d_v_r   <= 1'b0;
      o_v_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_k_r <= cfg_wdata;
      end
      k_lat_r <= k_lat_nxt;
      fill_r  <= fill_nxt;
      ptr_r   <= ptr_nxt;
      if (b_v_r && c_en) begin
        sum_r <= sum_nxt;
        zc_r  <= zc_nxt;
      end
      if (b_en) begin
        b_v_r <= in_acc;
      end
      if (c_en) begin
        c_v_r <= b_v_r;
      end
      if (d_en) begin
        d_v_r <= c_v_r;
      end
      if (o_en) begin
        o_v_r <= d_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      b_qc_r    <= in_chan.qual_char;
      b_first_r <= in_chan.first_of_read;
      b_evict_r <= !in_chan.first_of_read && evict;
      b_entry_r <= entry;
    end
    if (b_v_r && c_en) begin
      c_qc_r    <= b_qc_r;
      c_first_r <= b_first_r;
      c_sum_r   <= sum_nxt;
      c_zero_r  <= zc_nxt != '0;
    end
    if (c_v_r && d_en) begin
      d_qc_r    <= c_qc_r;
      d_first_r <= c_first_r;
      d_zero_r  <= c_zero_r;
      d_ge_r    <= ge_c;
    end
    if (d_v_r && o_en) begin
      o_char_r <= o_char_nxt;
    end
  end

  assign out_chan.valid      = o_v_r;
  assign out_chan.score_char = o_char_r;

  a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
    b_v_r && !b_first_r && b_evict_r && !ring_rd[FRAC_BITS]
      |-> sum_r >= SUM_W'(ring_rd))
    else $error("window sum would underflow on eviction");

  a_ring_hold : assert property (@(posedge clk) disable iff (!rst_n)
    b_v_r && !c_en |=> $stable(ring_rd))
    else $error("ring read data changed while stage held");

  a_first_clears : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_chan.first_of_read
      |=> b_v_r && b_first_r && fill_r == '0 && ptr_r == '0)
    else $error("first word of read did not restart the window");

  a_fill_bound : assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= k_lat_r && int'(ptr_r) < MAX_WINDOW)
    else $error("fill count or ring pointer out of range");

endmodule

>>> sim/tb_kmer_quality_reencoder_unit.sv
// ----------------------------------------------------------------------------
// tb_kmer_quality_reencoder_unit
// Streams quality words through the k-mer re-encoder and compares every
// result word with a local log-domain window predictor. Directed reads cover
// pass-through, zero quality, clamped characters and window settings.
// Random reads then run under several window settings with idle gaps on both
// sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_kmer_quality_reencoder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import kqr_pkg::*;

  localparam int MAX_WINDOW = 64;
  localparam int FRAC_BITS  = 40;
  localparam int TERM_W     = FRAC_BITS + 1;
  localparam int SUM_W      = 46;

  localparam logic [63:0] UNIT_Q62 = 64'h4000_0000_0000_0000;
  localparam logic [63:0] TWO_Q62  = 64'h8000_0000_0000_0000;

  localparam logic [QUAL_W-1:0] Q_HIGH = 7'd73;
  localparam logic [QUAL_W-1:0] Q_MID  = 7'd53;
  localparam logic [QUAL_W-1:0] Q_TOP  = 7'd126;
  localparam logic [QUAL_W-1:0] Q_ZERO = CHAR_BIAS;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [K_CFG_W-1:0]  cfg_wdata;

  kqr_in_if  in_chan ();
  kqr_out_if out_chan ();

  kmer_quality_reencoder_unit #(
    .MAX_WINDOW (MAX_WINDOW),
    .FRAC_BITS  (FRAC_BITS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

  logic [63:0]        phred_terms [TERM_COUNT];
  logic [TERM_W-1:0]  term_ring [MAX_WINDOW];
  logic [SUM_W-1:0]   window_sum;
  int                 zero_bases;
  int                 filled;
  int                 ring_pos;
  logic [K_CFG_W-1:0] k_setting;
  int                 k_active;

  logic [QUAL_W-1:0]  pending_scores [$];
  int                 fail_count = 0;
  int                 long_hold  = 0;
  bit                 steady     = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = 128'(a) * 128'(b);
    return prod[125:62];
  endfunction

  function automatic logic [63:0] log2_fraction(input logic [63:0] z_in);
    logic [63:0] z;
    logic [63:0] f;
    z = z_in;
    f = '0;
    for (int i = 1; i <= 60; i++) begin
      z = q62_mul(z, z);
      if (z >= TWO_Q62) begin
        z = z >> 1;
        f = f | (64'd1 << (60 - i));
      end
    end
    return f;
  endfunction

  function automatic logic [63:0] minus_log2(input logic [63:0] z_in);
    logic [63:0] z;
    logic [63:0] n;
    z = z_in;
    n = '0;
    if (z == '0) return 64'd7 << 60;
    while (z < UNIT_Q62 && n < 7) begin
      z = z << 1;
      n = n + 64'd1;
    end
    return (n << 60) - log2_fraction(z);
  endfunction

  task automatic build_phred_terms();
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] p;
    logic [63:0] x;
    logic [63:0] l10;
    logic [63:0] num;
    logic [63:0] q;
    logic [63:0] rem;
    lo = '0;
    hi = UNIT_Q62;
    for (int i = 0; i < 64; i++) begin
      mid = lo + (hi - lo) / 2;
      p = UNIT_Q62;
      for (int j = 0; j < 20; j++) p = q62_mul(p, mid);
      if (p <= UNIT_Q62 / 10) lo = mid;
      else hi = mid;
    end
    l10 = (64'd3 << 60) + log2_fraction(UNIT_Q62 + UNIT_Q62 / 4);
    x = UNIT_Q62;
    phred_terms[0] = '0;
    for (int h = 1; h < TERM_COUNT; h++) begin
      x = q62_mul(x, lo);
      num = minus_log2(UNIT_Q62 - x);
      q = num / l10;
      rem = num % l10;
      for (int i = 0; i <= FRAC_BITS; i++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= l10) begin
          rem = rem - l10;
          q[0] = 1'b1;
        end
      end
      phred_terms[h] = (q + 64'd1) >> 1;
    end
  endtask

  function automatic int clamp_window(input logic [K_CFG_W-1:0] k);
    if (k == '0) return 1;
    if (k > MAX_WINDOW) return MAX_WINDOW;
    return int'(k);
  endfunction

  task automatic kmer_score_step(input logic [QUAL_W-1:0] qc, input bit is_first,
                                 output logic [QUAL_W-1:0] score);
    int                t;
    int                old;
    int                hits;
    logic [TERM_W-1:0] entry;
    logic [TERM_W-1:0] leaving;
    if (is_first) begin
      window_sum = '0;
      zero_bases = 0;
      filled = 0;
      ring_pos = 0;
      k_active = clamp_window(k_setting);
      score = qc;
      return;
    end
    t = (qc < CHAR_BIAS) ? 0 : int'(qc) - int'(CHAR_BIAS);
    if (t > TOP_SCORE) t = TOP_SCORE;
    entry = (t == 0) ? (TERM_W'(1) << FRAC_BITS) : TERM_W'(phred_terms[2 * t]);
    if (filled >= k_active) begin
      old = (ring_pos + MAX_WINDOW - (k_active % MAX_WINDOW)) % MAX_WINDOW;
      leaving = term_ring[old];
      if (leaving[FRAC_BITS]) begin
        if (zero_bases > 0) zero_bases--;
      end else if (leaving <= window_sum) begin
        window_sum = window_sum - leaving;
      end else begin
        window_sum = '0;
      end
    end else begin
      filled++;
    end
    term_ring[ring_pos] = entry;
    ring_pos = (ring_pos + 1) % MAX_WINDOW;
    if (entry[FRAC_BITS]) zero_bases++;
    else window_sum = window_sum + entry;
    if (zero_bases > 0) begin
      score = CHAR_BIAS;
      return;
    end
    hits = 0;
    for (int m = 0; m < TOP_SCORE; m++)
      if (window_sum <= phred_terms[2 * m + 1]) hits++;
    score = CHAR_BIAS + QUAL_W'(hits);
  endtask

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic logic [QUAL_W-1:0] random_qual(input int noise);
    int r;
    r = $urandom_range(0, 99);
    if (r < noise / 2) return Q_ZERO;
    if (r < noise) return QUAL_W'($urandom_range(0, 127));
    if (r < noise + 12) return QUAL_W'($urandom_range(34, 52));
    return QUAL_W'($urandom_range(53, 126));
  endfunction

  initial begin : out_ready_drive
    int stall_left;
    stall_left = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold > 0) begin
        stall_left = long_hold;
        long_hold = 0;
      end
      if (stall_left > 0) begin
        out_chan.ready <= 1'b0;
        stall_left--;
      end else begin
        out_chan.ready <= 1'b1;
        if (!steady && $urandom_range(0, 99) < 20) stall_left = idle_len();
      end
    end
  end

  always @(posedge clk) begin : check_scores
    logic [QUAL_W-1:0] want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_scores.size() == 0) begin
        $error("score_char: expected none, actual %0d", out_chan.score_char);
        fail_count++;
      end else begin
        want = pending_scores.pop_front();
        if (out_chan.score_char !== want) begin
          $error("score_char: expected %0d, actual %0d", want, out_chan.score_char);
          fail_count++;
        end
      end
    end
  end

  task automatic send_word(input logic [QUAL_W-1:0] qc, input bit is_first);
    int                gap;
    logic [QUAL_W-1:0] score;
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.qual_char     <= qc;
    in_chan.first_of_read <= is_first;
    do @(posedge clk); while (!in_chan.ready);
    kmer_score_step(qc, is_first, score);
    pending_scores.push_back(score);
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_window_k(input logic [K_CFG_W-1:0] k);
    drain();
    cfg_wdata <= k;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    k_setting = k;
  endtask

  task automatic test_orphan_words();
    send_word(Q_HIGH, 1'b0);
    send_word(Q_MID, 1'b0);
    send_word(Q_TOP, 1'b0);
  endtask

  task automatic test_first_word_passthrough();
    send_word(7'd0, 1'b1);
    send_word(7'd127, 1'b1);
    send_word(Q_ZERO, 1'b1);
  endtask

  task automatic test_zero_quality();
    send_word(Q_HIGH, 1'b1);
    send_word(Q_ZERO, 1'b0);
    send_word(Q_HIGH, 1'b0);
    send_word(Q_HIGH, 1'b0);
    send_word(Q_HIGH, 1'b0);
  endtask

  task automatic test_char_clamping();
    send_word(Q_HIGH, 1'b1);
    send_word(7'd0, 1'b0);
    send_word(Q_HIGH, 1'b0);
    send_word(Q_HIGH, 1'b0);
    send_word(7'd127, 1'b0);
    send_word(7'd32, 1'b0);
  endtask

  task automatic test_score_saturation();
    set_window_k(7'd1);
    send_word(Q_HIGH, 1'b1);
    send_word(Q_TOP, 1'b0);
    send_word(Q_TOP, 1'b0);
  endtask

  task automatic test_window_k_clamp();
    set_window_k(7'd0);
    send_word(Q_HIGH, 1'b1);
    send_word(Q_MID, 1'b0);
    set_window_k(7'd127);
    send_word(Q_HIGH, 1'b1);
    send_word(Q_MID, 1'b0);
  endtask

  task automatic test_window_k_in_read();
    set_window_k(7'd2);
    send_word(Q_MID, 1'b1);
    send_word(Q_MID, 1'b0);
    set_window_k(7'd5);
    send_word(Q_MID, 1'b0);
    send_word(Q_MID, 1'b0);
    send_word(Q_MID, 1'b1);
  endtask

  task automatic run_random_phase(input logic [K_CFG_W-1:0] k, input int noise,
                                  input bit no_gaps, input bit squeeze, input int words);
    int sent;
    int len;
    int klen;
    int r;
    bit squeezed;
    set_window_k(k);
    steady = no_gaps;
    klen = clamp_window(k);
    sent = 0;
    squeezed = 1'b0;
    if ($urandom_range(0, 1) == 1) begin
      len = $urandom_range(1, 10);
      repeat (len) send_word(random_qual(noise), 1'b0);
      sent += len;
    end
    while (sent < words) begin
      r = $urandom_range(0, 99);
      if (r < 70) len = $urandom_range(1, klen + 8);
      else if (r < 95) len = $urandom_range(1, 40);
      else len = $urandom_range(60, 140);
      send_word(random_qual(noise), 1'b1);
      for (int i = 1; i < len; i++) begin
        send_word(random_qual(noise), 1'b0);
        if (squeeze && !squeezed && sent + i >= 60) begin
          long_hold = 300;
          squeezed = 1'b1;
        end
      end
      sent += len;
    end
    steady = 1'b0;
  endtask

  task automatic test_random_reads();
    run_random_phase(7'd1, 10, 1'b0, 1'b0, 200);
    run_random_phase(7'd64, 1, 1'b0, 1'b1, 200);
    run_random_phase(7'd127, 1, 1'b0, 1'b0, 200);
    run_random_phase(7'd0, 10, 1'b1, 1'b0, 200);
    run_random_phase(7'd2, 6, 1'b0, 1'b0, 200);
    run_random_phase(7'd7, 6, 1'b0, 1'b0, 200);
    run_random_phase(7'd33, 3, 1'b0, 1'b0, 200);
    run_random_phase(K_CFG_W'($urandom_range(0, 127)), 6, 1'b0, 1'b0, 200);
  endtask

  initial begin
    build_phred_terms();
    for (int i = 0; i < MAX_WINDOW; i++) term_ring[i] = '0;
    window_sum = '0;
    zero_bases = 0;
    filled = 0;
    ring_pos = 0;
    k_setting = K_CFG_W'(K_RESET);
    k_active = K_RESET;
    in_chan.valid = 1'b0;
    in_chan.qual_char = '0;
    in_chan.first_of_read = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_orphan_words();
    test_first_word_passthrough();
    test_zero_quality();
    test_char_clamping();
    test_score_saturation();
    test_window_k_clamp();
    test_window_k_in_read();
    test_random_reads();

    drain();
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
